FILE: hdl/tsfq_pkg.sv
// ----------------------------------------------------------------------------
// tsfq_pkg
// Shared constants, codes and types of the timestamp sorted frame queue.
// ----------------------------------------------------------------------------
package tsfq_pkg;

  // Queue geometry
  localparam int DEPTH       = 16;
  localparam int HANDLE_BITS = 8;
  localparam int STAMP_W     = 64;
  localparam int FUNC_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int OCC_W       = 5;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int ENTRY_W     = STAMP_W + HANDLE_BITS;

  // Operation codes
  typedef logic [FUNC_W-1:0] func_t;
  localparam func_t FUNC_INSERT = 2'd0;
  localparam func_t FUNC_POP    = 2'd1;
  localparam func_t FUNC_CLEAR  = 2'd2;

  // Status codes
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_FULL  = 2'd1;
  localparam status_t STAT_EMPTY = 2'd2;

  // One stored entry
  typedef struct packed {
    logic [STAMP_W-1:0]     stamp;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  // Control sequencer states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_PLACE = 4'b0100,
    ST_POP   = 4'b1000
  } state_t;

endpackage

FILE: hdl/timestamp_sorted_frame_queue.sv
// ----------------------------------------------------------------------------
// timestamp_sorted_frame_queue
// Stable priority queue of frame handles ordered by 64-bit timestamp.
// ----------------------------------------------------------------------------
// Usage:
//   An item (in_func, in_frame_handle, in_stamp_in) is taken at a rising edge
//   with start high and busy low. Insert places the entry after all entries
//   with a lower or equal stamp, pop returns the oldest entry, clear empties
//   the queue. Every item gives one result, shown for one cycle with
//   out_strobe high; the receiver cannot stall it.
//   Entries live in one RAM (stamp and handle side by side) arranged as a
//   ring: a head pointer marks the oldest entry, so pop only moves the head.
//   Insert walks back from the tail, one read/compare/write of the RAM per
//   cycle, moving each later entry up by one slot until the new one fits.
//   Insert into an empty queue, full insert, clear, empty pop and func 3 are
//   answered straight from the accept; pop reads the head entry from the RAM
//   in ST_POP; insert into a non-empty queue walks ST_SCAN past every entry
//   with a larger stamp and ends in ST_SCAN or ST_PLACE. For those two, busy
//   is high from the cycle after accept until the result is registered.
//   Reset (synchronous) empties the queue; RAM contents need no clearing.
// ----------------------------------------------------------------------------
module timestamp_sorted_frame_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [tsfq_pkg::FUNC_W-1:0]   in_func,
  input  logic [7:0]                    in_frame_handle,
  input  logic [tsfq_pkg::STAMP_W-1:0]  in_stamp_in,
  output logic                       out_strobe,
  output logic                       out_pop_valid,
  output logic [7:0]                    out_pop_handle,
  output logic [tsfq_pkg::STAMP_W-1:0]  out_pop_stamp,
  output logic [tsfq_pkg::OCC_W-1:0]    out_occupancy,
  output logic [tsfq_pkg::STATUS_W-1:0] out_status
);

  import tsfq_pkg::*;

  // ring address of a logical slot
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [IDX_W-1:0] lpos);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, lpos};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // control state
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  entry_t           new_r, new_nxt;

  // result registers
  logic                   out_strobe_r;
  logic                   out_pop_valid_r;
  logic [7:0]             out_pop_handle_r;
  logic [STAMP_W-1:0]     out_pop_stamp_r;
  logic [OCC_W-1:0]       out_occupancy_r;
  status_t                out_status_r;

  // RAM port signals
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;

  // result control
  logic    accept;
  logic    emit;
  logic    emit_pop;
  status_t emit_status;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  tsfq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer: dispatches each item; an insert walk reads, compares and writes back one slot per cycle
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    head_nxt    = head_r;
    pos_nxt     = pos_r;
    new_nxt     = new_r;
    wr_en       = 1'b0;
    wr_addr     = phys(head_r, pos_r);
    wr_data     = new_r;
    rd_addr     = head_r;
    emit        = 1'b0;
    emit_pop    = 1'b0;
    emit_status = STAT_OK;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (in_func == FUNC_INSERT) begin
            priority if (count_r == CNT_W'(DEPTH)) begin
              emit        = 1'b1;
              emit_status = STAT_FULL;
            end else if (count_r == '0) begin
              // empty queue: store at the head directly
              wr_en     = 1'b1;
              wr_addr   = head_r;
              wr_data   = '{stamp: in_stamp_in, handle: in_frame_handle[HANDLE_BITS-1:0]};
              count_nxt = count_r + CNT_W'(1);
              emit      = 1'b1;
            end else begin
              // start walking back from the tail
              new_nxt   = '{stamp: in_stamp_in, handle: in_frame_handle[HANDLE_BITS-1:0]};
              pos_nxt   = count_r[IDX_W-1:0];
              rd_addr   = phys(head_r, IDX_W'(count_r - CNT_W'(1)));
              state_nxt = ST_SCAN;
            end
          end else if (in_func == FUNC_POP) begin
            if (count_r == '0) begin
              emit        = 1'b1;
              emit_status = STAT_EMPTY;
            end else begin
              rd_addr   = head_r;
              state_nxt = ST_POP;
            end
          end else if (in_func == FUNC_CLEAR) begin
            count_nxt = '0;
            emit      = 1'b1;
          end else begin
            emit = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        // rd_data holds logical slot pos_r - 1
        if (rd_data.stamp > new_r.stamp) begin
          wr_en   = 1'b1;
          wr_data = rd_data;
          pos_nxt = pos_r - IDX_W'(1);
          if (pos_r == IDX_W'(1)) begin
            state_nxt = ST_PLACE;
          end else begin
            rd_addr = phys(head_r, pos_r - IDX_W'(2));
          end
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_PLACE: begin
        // new entry becomes the oldest
        wr_en     = 1'b1;
        count_nxt = count_r + CNT_W'(1);
        emit      = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_POP: begin
        emit_pop  = 1'b1;
        head_nxt  = phys(head_r, IDX_W'(1));
        count_nxt = count_r - CNT_W'(1);
        emit      = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      head_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      head_r       <= head_nxt;
      out_strobe_r <= emit;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    new_r <= new_nxt;
    if (emit) begin
      out_pop_valid_r  <= emit_pop;
      out_pop_handle_r <= emit_pop ? 8'(rd_data.handle) : 8'd0;
      out_pop_stamp_r  <= emit_pop ? rd_data.stamp : '0;
      out_occupancy_r  <= OCC_W'(count_nxt);
      out_status_r     <= emit_status;
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_pop_valid  = out_pop_valid_r;
  assign out_pop_handle = out_pop_handle_r;
  assign out_pop_stamp  = out_pop_stamp_r;
  assign out_occupancy  = out_occupancy_r;
  assign out_status     = out_status_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above queue depth");

  a_scan_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (pos_r != '0))
    else $error("insert walk reached slot zero while scanning");

  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |=> (out_strobe_r && out_pop_valid_r))
    else $error("pop did not deliver an entry");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && (out_status_r == STAT_FULL)) |-> (out_occupancy_r == OCC_W'(DEPTH)))
    else $error("full status with queue not full");

endmodule

FILE: hdl/tsfq_ram.sv
// ----------------------------------------------------------------------------
// tsfq_ram
// Generic simple dual port RAM: one write port, one read port, read data
// registered (old data on a same address collision).
// ----------------------------------------------------------------------------
module tsfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
